// ===== hw/rtl/wsts_pkg.sv =====
// shared types and constants for the work-stealing task scheduler
// no dependencies; imported by the top level and its port checker
`default_nettype none

package wsts_pkg;

    // fixed field widths of the stream payloads
    localparam int REQ_W       = 2;
    localparam int WID_W       = 3;
    localparam int TASK_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int PEND_W      = 7;
    localparam int WC_W        = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // parameter defaults
    localparam int WORKERS_DEF   = 8;
    localparam int DEPTH_DEF     = 64;
    localparam int TASK_BITS_DEF = 16;

    // register reset values
    localparam logic [WC_W-1:0]   WC_RESET    = 4'd8;
    localparam logic [PEND_W-1:0] LIMIT_RESET = 7'd64;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_WORKERS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE  = 2'd0,
        REQ_FETCH    = 2'd1,
        REQ_COMPLETE = 2'd2,
        REQ_STOP     = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_STOPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_IDLE    = 3'd3,
        ST_EXIT    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_MEM,
        S_RDWAIT,
        S_DONE
    } fsm_t;

endpackage

`default_nettype wire

// ===== hw/rtl/work_stealing_task_scheduler_top.sv =====
// work-stealing task scheduler: per-worker deques in a task memory plus a control memory
// depends on wsts_pkg
`default_nettype none

// Usage
// - s_* stream carries one request per transaction (enqueue, fetch, complete, stop);
//   m_* stream returns exactly one result transaction per request, in order.
// - cfg_* channel writes the active worker count (index 0) or queue_limit (index 1);
//   write only while no request is outstanding. cfg_ready is always high.
// - Requests are handled one at a time. Complete, stop and early rejects pass only
//   through the start and finishing states. Enqueue and fetch scan the per-worker
//   control memory one entry per cycle over the n active workers (n = active worker
//   count), then touch the task memory; a fetch also passes a read-wait state.
//   The task memory is skipped if every queue is full or there is nothing to fetch.
// - The result sits in an output register, so a new request is accepted while a result
//   waits on m_tready.
// - If the receiver stalls, the next result is held in its finishing state until the
//   output register frees up; no result is dropped.
// - Reset (rst_n low, asynchronous) empties all queues, clears the pending count and
//   stop flag, and sets 8 active workers and queue_limit 64. No clearing pass is needed:
//   control entries carry valid bits, and the task memory is only read where written.
module work_stealing_task_scheduler_top #(
    parameter int WORKERS   = wsts_pkg::WORKERS_DEF,
    parameter int DEPTH     = wsts_pkg::DEPTH_DEF,
    parameter int TASK_BITS = wsts_pkg::TASK_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request: req_type[1:0], wid[4:2], task_id[20:5], zero pad [23:21]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [wsts_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result: status[2:0], worker_sel[5:3], task_out[21:6], stolen[22],
    //         pending_total[29:23], zero pad [31:30]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [wsts_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wsts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wsts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wsts_pkg::*;

    localparam int WA    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int IW    = $clog2(WORKERS + 1);
    localparam int CW    = (IW > WID_W) ? IW : WID_W;
    localparam int HW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int TW    = (TASK_BITS < TASK_W) ? TASK_BITS : TASK_W;
    localparam int SLOTS = WORKERS * DEPTH;
    localparam int SA    = $clog2(SLOTS);

    typedef struct packed {
        logic [HW-1:0] head;
        logic [LW-1:0] len;
    } ctl_t;

    // control and configuration registers
    fsm_t              state_reg, state_next;
    logic [WC_W-1:0]   wc_reg;
    logic [PEND_W-1:0] limit_reg;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              stop_reg, stop_next;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    req_t                   req_reg, req_next;
    logic [WID_W-1:0]       wid_reg, wid_next;
    logic [TW-1:0]          task_reg, task_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic [WA-1:0]          best_reg, best_next;
    logic [LW-1:0]          best_len_reg, best_len_next;
    logic [HW-1:0]          best_head_reg, best_head_next;
    logic [LW-1:0]          own_len_reg, own_len_next;
    logic [HW-1:0]          own_head_reg, own_head_next;
    status_t                status_reg, status_next;
    logic [WA-1:0]          sel_reg, sel_next;
    logic                   stolen_reg, stolen_next;
    logic [TW-1:0]          tout_reg, tout_next;
    logic [SA-1:0]          ts_addr_reg, ts_addr_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // memories
    ctl_t             ctl_mem [WORKERS];
    logic [WORKERS-1:0] ctl_vld_reg;
    ctl_t             ctl_rd_reg;
    logic             ctl_rd_vld_reg;
    logic [TW-1:0]    ts_mem [SLOTS];
    logic [TW-1:0]    ts_rd_reg;

    // memory port controls
    logic          ctl_re, ctl_we;
    logic [WA-1:0] ctl_raddr, ctl_waddr;
    ctl_t          ctl_wdata;
    logic          ts_we, ts_re;

    // derived values
    logic [WC_W+3-1:0] wc_ext;
    logic [IW-1:0]     n_act;
    logic [LW-1:0]     cur_len;
    logic [HW-1:0]     cur_head;
    logic              is_own;
    logic              s_fire;
    logic [WA-1:0]     q_sel;
    logic [HW-1:0]     head_sel, off_sel;
    logic [HW:0]       sum_raw, sum_wrap;
    logic [HW:0]       inc_raw, inc_wrap;
    logic [SA:0]       slot_wide;
    logic [CW-1:0]     sel_wide;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // active worker count, clamped to 1..WORKERS
    assign wc_ext = {3'b000, wc_reg};
    always_comb
    begin
        if (wc_reg == '0)
        begin
            n_act = IW'(1);
        end
        else if (wc_ext > (WC_W+3)'(WORKERS))
        begin
            n_act = IW'(WORKERS);
        end
        else
        begin
            n_act = IW'(wc_reg);
        end
    end

    // control entry returned by the scan; unwritten entries read as empty queues
    assign cur_len  = ctl_rd_vld_reg ? ctl_rd_reg.len  : '0;
    assign cur_head = ctl_rd_vld_reg ? ctl_rd_reg.head : '0;
    assign is_own   = (CW'(rd_idx_reg) == CW'(wid_reg));

    // slot address: queue base plus wrapped offset from the head
    always_comb
    begin
        q_sel    = best_reg;
        head_sel = best_head_reg;
        off_sel  = best_len_reg[HW-1:0];
        if (req_reg == REQ_FETCH)
        begin
            if (own_len_reg != '0)
            begin
                q_sel    = WA'(wid_reg);
                head_sel = own_head_reg;
                off_sel  = '0;
            end
            else
            begin
                off_sel = HW'(best_len_reg - LW'(1));
            end
        end
    end

    assign sum_raw   = {1'b0, head_sel} + {1'b0, off_sel};
    assign sum_wrap  = (sum_raw >= (HW+1)'(DEPTH)) ? sum_raw - (HW+1)'(DEPTH) : sum_raw;
    assign slot_wide = (SA+1)'(q_sel) * (SA+1)'(DEPTH) + (SA+1)'(sum_wrap);

    // own head advanced by one after a pop from the front
    assign inc_raw  = {1'b0, own_head_reg} + (HW+1)'(1);
    assign inc_wrap = (inc_raw >= (HW+1)'(DEPTH)) ? inc_raw - (HW+1)'(DEPTH) : inc_raw;

    assign sel_wide = CW'(sel_reg);

    // next state, datapath updates and memory controls
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        stop_next      = stop_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        wid_next       = wid_reg;
        task_next      = task_reg;
        best_next      = best_reg;
        best_len_next  = best_len_reg;
        best_head_next = best_head_reg;
        own_len_next   = own_len_reg;
        own_head_next  = own_head_reg;
        status_next    = status_reg;
        sel_next       = sel_reg;
        stolen_next    = stolen_reg;
        tout_next      = tout_reg;
        ts_addr_next   = ts_addr_reg;
        out_data_next  = out_data_reg;
        ctl_re         = 1'b0;
        ctl_raddr      = scan_idx_reg[WA-1:0];
        ctl_we         = 1'b0;
        ctl_waddr      = q_sel;
        ctl_wdata      = '{head: best_head_reg, len: best_len_reg};
        ts_we          = 1'b0;
        ts_re          = 1'b0;

        // result leaves the output register
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    req_next   = req_t'(s_tdata[REQ_W-1:0]);
                    wid_next   = s_tdata[REQ_W +: WID_W];
                    task_next  = s_tdata[REQ_W+WID_W +: TW];
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next    = ST_OK;
                sel_next       = '0;
                stolen_next    = 1'b0;
                tout_next      = '0;
                scan_idx_next  = '0;
                best_len_next  = '0;
                best_head_next = '0;
                own_len_next   = '0;
                own_head_next  = '0;
                best_next      = (req_reg == REQ_FETCH) ? WA'(wid_reg) : '0;
                state_next     = S_DONE;
                case (req_reg)
                    REQ_ENQUEUE:
                    begin
                        if (stop_reg)
                        begin
                            status_next = ST_STOPPED;
                        end
                        else if (pend_reg >= limit_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_FETCH:
                    begin
                        if (CW'(wid_reg) >= CW'(n_act))
                        begin
                            status_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_COMPLETE:
                    begin
                        if (pend_reg != '0)
                        begin
                            pend_next = pend_reg - PEND_W'(1);
                        end
                    end
                    default:
                    begin
                        stop_next = 1'b1;
                    end
                endcase
            end

            S_SCAN:
            begin
                // issue one control read per cycle
                if (scan_idx_reg < n_act)
                begin
                    ctl_re        = 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
                // fold in the entry read last cycle
                if (rd_pend_reg)
                begin
                    if (req_reg == REQ_ENQUEUE)
                    begin
                        if ((rd_idx_reg == '0) || (cur_len < best_len_reg))
                        begin
                            best_next      = rd_idx_reg[WA-1:0];
                            best_len_next  = cur_len;
                            best_head_next = cur_head;
                        end
                    end
                    else
                    begin
                        if (is_own)
                        begin
                            own_len_next  = cur_len;
                            own_head_next = cur_head;
                        end
                        else if (cur_len > best_len_reg)
                        begin
                            best_next      = rd_idx_reg[WA-1:0];
                            best_len_next  = cur_len;
                            best_head_next = cur_head;
                        end
                    end
                end
                else if (scan_idx_reg == n_act)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                ts_addr_next = slot_wide[SA-1:0];
                sel_next     = q_sel;
                state_next   = S_MEM;
                if (req_reg == REQ_ENQUEUE)
                begin
                    if (best_len_reg >= LW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        sel_next    = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ctl_we    = 1'b1;
                        ctl_wdata = '{head: best_head_reg, len: best_len_reg + LW'(1)};
                        pend_next = pend_reg + PEND_W'(1);
                    end
                end
                else if (own_len_reg != '0)
                begin
                    ctl_we    = 1'b1;
                    ctl_wdata = '{head: inc_wrap[HW-1:0], len: own_len_reg - LW'(1)};
                end
                else if (best_reg != WA'(wid_reg))
                begin
                    ctl_we      = 1'b1;
                    ctl_wdata   = '{head: best_head_reg, len: best_len_reg - LW'(1)};
                    stolen_next = 1'b1;
                end
                else
                begin
                    status_next = stop_reg ? ST_EXIT : ST_IDLE;
                    sel_next    = '0;
                    state_next  = S_DONE;
                end
            end

            S_MEM:
            begin
                if (req_reg == REQ_ENQUEUE)
                begin
                    ts_we      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ts_re      = 1'b1;
                    state_next = S_RDWAIT;
                end
            end

            S_RDWAIT:
            begin
                tout_next  = ts_rd_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, pend_reg, stolen_reg, TASK_W'(tout_reg),
                                      sel_wide[WID_W-1:0], status_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers and configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= WC_RESET;
            limit_reg     <= LIMIT_RESET;
            pend_reg      <= '0;
            stop_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_vld_reg   <= '0;
        end
        else
        begin
            pend_reg      <= pend_next;
            stop_reg      <= stop_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (ctl_we)
            begin
                ctl_vld_reg[ctl_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ACT_WORKERS:  wc_reg    <= cfg_data[WC_W-1:0];
                    CFG_QUEUE_LIMIT:  limit_reg <= cfg_data;
                    default:          limit_reg <= limit_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        wid_reg       <= wid_next;
        task_reg      <= task_next;
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_len_reg  <= best_len_next;
        best_head_reg <= best_head_next;
        own_len_reg   <= own_len_next;
        own_head_reg  <= own_head_next;
        status_reg    <= status_next;
        sel_reg       <= sel_next;
        stolen_reg    <= stolen_next;
        tout_reg      <= tout_next;
        ts_addr_reg   <= ts_addr_next;
        out_data_reg  <= out_data_next;
    end

    // per-worker control memory: head and length of each deque
    // writes happen only after the scan, so a read never meets a write to the same entry
    always_ff @(posedge clk)
    begin
        if (ctl_we)
        begin
            ctl_mem[ctl_waddr] <= ctl_wdata;
        end
        if (ctl_re)
        begin
            ctl_rd_reg     <= ctl_mem[ctl_raddr];
            ctl_rd_vld_reg <= ctl_vld_reg[ctl_raddr];
        end
    end

    // task memory: DEPTH slots per worker
    always_ff @(posedge clk)
    begin
        if (ts_we)
        begin
            ts_mem[ts_addr_reg] <= task_reg;
        end
        if (ts_re)
        begin
            ts_rd_reg <= ts_mem[ts_addr_reg];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wsts_checker.sv =====
// port-level checks for the work-stealing task scheduler, bound to the top level
// depends on wsts_pkg and work_stealing_task_scheduler_top
`default_nettype none

module wsts_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [wsts_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import wsts_pkg::*;

    // status code stays within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_EXIT))
        else $error("result status out of range");

    // a result that is not ok carries no queue, task or steal mark
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)) |-> (m_tdata[22:3] == '0))
        else $error("non-ok result carries task fields");

    // one request in flight: ready drops after an accepted transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind work_stealing_task_scheduler_top wsts_checker u_wsts_checker (.*);

`default_nettype wire
